// ===== sv/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define SHL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SHL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/shlock_pkg.sv =====
`default_nettype none

package shlock_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int ID_WIDTH   = 8;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_REQ  = 2'd0,
        MODE_REL  = 2'd1,
        MODE_REM  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_SCAN   = 7'b0000100,
        ST_PRO_A  = 7'b0001000,
        ST_PRO_B  = 7'b0010000,
        ST_PRO_C  = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;
        logic grant_direct;
        logic holder_clear;
        logic scan;
        logic drop;
        logic append;
        logic drop_commit;
        logic pro_a;
        logic pro_b;
        logic pro_c;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  holder_flag;
        logic  holder_match;
        logic  scan_done;
        logic  found;
        logic  can_promote;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/single_holder_lock_with_wait_list.sv =====
`default_nettype none

// Lock arbiter for one shared right: one holder plus an ordered wait list
// of up to LIST_DEPTH ids held in a single-port-read RAM. Each transaction
// (mode, agent_id) gives exactly one result. A request while the lock is
// free goes from decode straight to finish. Requests while held, removals
// and releases by a non-holder scan the list one entry per cycle through
// the RAM read port; a waiter is promoted through PRO_A, PRO_B and PRO_C.
// The controller returns to idle as the result is loaded and accepts only
// in idle, so it takes one transaction at a time. The result sits in an
// output register, so the next transaction is accepted while it waits to
// be taken. No clearing pass after reset: the list is only read below its
// fill count.

`include "assert_macros.svh"

module single_holder_lock_with_wait_list
    import shlock_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_mode,
    input  wire logic [7:0] s_agent_id,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_request_granted,
    output logic            m_grant_made,
    output logic      [7:0] m_grant_target,
    output logic            m_holder_present,
    output logic      [7:0] m_holder_now,
    output logic      [4:0] m_waiting_total,
    output logic            m_list_overflow
);

    cmd_t cmd;
    sts_t sts;

    shlock_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    shlock_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_mode            (s_mode),
        .s_agent_id        (s_agent_id),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_request_granted (m_request_granted),
        .m_grant_made      (m_grant_made),
        .m_grant_target    (m_grant_target),
        .m_holder_present  (m_holder_present),
        .m_holder_now      (m_holder_now),
        .m_waiting_total   (m_waiting_total),
        .m_list_overflow   (m_list_overflow),
        .cmd               (cmd),
        .sts               (sts)
    );

    `SHL_ASSERT_ALWAYS(a_grant_holds, !m_valid || !m_grant_made || m_holder_present, "grant without holder")
    `SHL_ASSERT_ALWAYS(a_direct_grant, !m_valid || !m_request_granted || (m_grant_made && m_holder_now == m_grant_target), "direct grant mismatch")
    `SHL_ASSERT_ALWAYS(a_overflow_full, !m_valid || !m_list_overflow || (m_waiting_total == 5'(LIST_DEPTH)), "overflow with room left")
    `SHL_ASSERT_ALWAYS(a_single_cmd, !(cmd.load && cmd.out_load) && !(cmd.scan && cmd.append), "conflicting datapath commands")

endmodule

`default_nettype wire

// ===== sv/shlock_ram.sv =====
`default_nettype none

module shlock_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/shlock_ctrl.sv =====
`default_nettype none

module shlock_ctrl
    import shlock_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (sts.mode)
                    MODE_REQ: begin
                        if (!sts.holder_flag) begin
                            cmd.grant_direct = 1'b1;
                            state_next       = ST_FINISH;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    MODE_REL: begin
                        if (sts.holder_match) begin
                            cmd.holder_clear = 1'b1;
                            state_next       = ST_PRO_A;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    MODE_REM: begin
                        cmd.holder_clear = sts.holder_match;
                        state_next       = ST_SCAN;
                    end
                    MODE_NONE: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.drop = (sts.mode != MODE_REQ);
                if (!sts.scan_done) begin
                    cmd.scan = 1'b1;
                end else if (sts.mode == MODE_REQ) begin
                    cmd.append = !sts.found;
                    state_next = ST_FINISH;
                end else begin
                    cmd.drop_commit = 1'b1;
                    state_next      = (sts.mode == MODE_REM) ? ST_PRO_A : ST_FINISH;
                end
            end
            ST_PRO_A: begin
                if (sts.can_promote) begin
                    cmd.pro_a  = 1'b1;
                    state_next = ST_PRO_B;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_PRO_B: begin
                cmd.pro_b  = 1'b1;
                state_next = ST_PRO_C;
            end
            ST_PRO_C: begin
                cmd.pro_c  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/shlock_dp.sv =====
`default_nettype none

module shlock_dp
    import shlock_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] s_mode,
    input  wire logic [7:0] s_agent_id,
    input  wire logic       m_ready,
    output logic            m_valid,
    output logic            m_request_granted,
    output logic            m_grant_made,
    output logic      [7:0] m_grant_target,
    output logic            m_holder_present,
    output logic      [7:0] m_holder_now,
    output logic      [4:0] m_waiting_total,
    output logic            m_list_overflow,
    input  wire cmd_t       cmd,
    output sts_t            sts
);

    mode_t               mode_reg, mode_next;
    logic [ID_WIDTH-1:0] id_reg, id_next;
    logic                holder_flag_reg, holder_flag_next;
    logic [ID_WIDTH-1:0] holder_id_reg, holder_id_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]    wr_idx_reg, wr_idx_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    logic                granted_now_reg, granted_now_next;
    logic                grant_reg, grant_next;
    logic [ID_WIDTH-1:0] target_reg, target_next;
    logic                overflow_reg, overflow_next;
    logic                m_valid_reg, m_valid_next;

    logic                ram_we, ram_re;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr;
    logic [ID_WIDTH-1:0] ram_wdata, ram_rdata;

    logic                scan_issue, keep, has_room;
    logic [CNT_W-1:0]    cnt_dec;

    shlock_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_wait_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign scan_issue = (rd_idx_reg < count_reg);
    assign keep       = (ram_rdata != id_reg);
    assign has_room   = (count_reg < CNT_W'(LIST_DEPTH));
    assign cnt_dec    = count_reg - CNT_W'(1);

    assign sts.mode         = mode_reg;
    assign sts.holder_flag  = holder_flag_reg;
    assign sts.holder_match = holder_flag_reg && (holder_id_reg == id_reg);
    assign sts.scan_done    = !scan_issue && !pend_reg;
    assign sts.found        = found_reg;
    assign sts.can_promote  = !holder_flag_reg && (count_reg != '0);
    assign sts.out_free     = !m_valid_reg || m_ready;

    // wait list memory ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (cmd.scan && cmd.drop && pend_reg && keep) begin
            ram_we = 1'b1;
        end else if (cmd.append && has_room) begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata = id_reg;
        end else if (cmd.pro_c) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
        end
        ram_re    = (cmd.scan && scan_issue) || cmd.pro_a || cmd.pro_b;
        ram_raddr = rd_idx_reg[IDX_W-1:0];
        if (cmd.pro_a) begin
            ram_raddr = '0;
        end else if (cmd.pro_b) begin
            ram_raddr = cnt_dec[IDX_W-1:0];
        end
    end

    always_comb begin
        mode_next        = mode_reg;
        id_next          = id_reg;
        holder_flag_next = holder_flag_reg;
        holder_id_next   = holder_id_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        wr_idx_next      = wr_idx_reg;
        found_next       = found_reg;
        granted_now_next = granted_now_reg;
        grant_next       = grant_reg;
        target_next      = target_reg;
        overflow_next    = overflow_reg;
        pend_next        = cmd.scan && scan_issue;

        if (cmd.load) begin
            mode_next        = mode_t'(s_mode);
            id_next          = s_agent_id[ID_WIDTH-1:0];
            rd_idx_next      = '0;
            wr_idx_next      = '0;
            found_next       = 1'b0;
            granted_now_next = 1'b0;
            grant_next       = 1'b0;
            target_next      = '0;
            overflow_next    = 1'b0;
        end
        if (cmd.grant_direct) begin
            holder_flag_next = 1'b1;
            holder_id_next   = id_reg;
            granted_now_next = 1'b1;
            grant_next       = 1'b1;
            target_next      = id_reg;
        end
        if (cmd.holder_clear) begin
            holder_flag_next = 1'b0;
            holder_id_next   = '0;
        end
        if (cmd.scan) begin
            if (scan_issue) begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (pend_reg) begin
                if (cmd.drop) begin
                    if (keep) begin
                        wr_idx_next = wr_idx_reg + CNT_W'(1);
                    end
                end else if (!keep) begin
                    found_next = 1'b1;
                end
            end
        end
        if (cmd.append) begin
            if (has_room) begin
                count_next = count_reg + CNT_W'(1);
            end else begin
                overflow_next = 1'b1;
            end
        end
        if (cmd.drop_commit) begin
            count_next = wr_idx_reg;
        end
        if (cmd.pro_b) begin
            holder_flag_next = 1'b1;
            holder_id_next   = ram_rdata;
            grant_next       = 1'b1;
            target_next      = ram_rdata;
        end
        if (cmd.pro_c) begin
            count_next = cnt_dec;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            holder_flag_reg <= 1'b0;
            holder_id_reg   <= '0;
            count_reg       <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            holder_flag_reg <= holder_flag_next;
            holder_id_reg   <= holder_id_next;
            count_reg       <= count_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg        <= mode_next;
        id_reg          <= id_next;
        rd_idx_reg      <= rd_idx_next;
        wr_idx_reg      <= wr_idx_next;
        found_reg       <= found_next;
        granted_now_reg <= granted_now_next;
        grant_reg       <= grant_next;
        target_reg      <= target_next;
        overflow_reg    <= overflow_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_request_granted <= granted_now_reg;
            m_grant_made      <= grant_reg;
            m_grant_target    <= grant_reg ? 8'(target_reg) : 8'd0;
            m_holder_present  <= holder_flag_reg;
            m_holder_now      <= holder_flag_reg ? 8'(holder_id_reg) : 8'd0;
            m_waiting_total   <= 5'(count_reg);
            m_list_overflow   <= overflow_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== dv/lock_status_checker.sv =====
`timescale 1ns / 1ps

module lock_status_checker
    import shlock_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_agent_id,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_request_granted,
    input  logic       m_grant_made,
    input  logic [7:0] m_grant_target,
    input  logic       m_holder_present,
    input  logic [7:0] m_holder_now,
    input  logic [4:0] m_waiting_total,
    input  logic       m_list_overflow,
    output int         fail_count,
    output int         pending,
    output int         events_seen,
    output int         direct_grants,
    output int         promotions,
    output int         list_drops
);

    typedef struct packed {
        logic       request_granted;
        logic       grant_made;
        logic [7:0] grant_target;
        logic       holder_present;
        logic [7:0] holder_now;
        logic [4:0] waiting_total;
        logic       list_overflow;
    } lock_status_t;

    // shadow of the lock state
    logic       holder_on;
    logic [7:0] holder_id;
    logic [7:0] waiters [LIST_DEPTH];
    int         waiter_cnt;

    lock_status_t due_status_q [$];
    int mismatches;
    int n_events;
    int n_direct;
    int n_promote;
    int n_drop;

    initial begin
        fail_count    = 0;
        pending       = 0;
        events_seen   = 0;
        direct_grants = 0;
        promotions    = 0;
        list_drops    = 0;
        mismatches    = 0;
        n_events      = 0;
        n_direct      = 0;
        n_promote     = 0;
        n_drop        = 0;
        holder_on     = 1'b0;
        holder_id     = '0;
        waiter_cnt    = 0;
    end

    // remove every copy of id, keeping order
    task automatic take_off_list(input logic [7:0] id);
        int w;
        w = 0;
        for (int r = 0; r < waiter_cnt; r++) begin
            if (waiters[r] != id) begin
                waiters[w] = waiters[r];
                w++;
            end
        end
        waiter_cnt = w;
    endtask

    // head of list becomes holder, last entry moves into slot 0
    task automatic promote_head(inout lock_status_t st);
        if (!holder_on && waiter_cnt > 0) begin
            st.grant_made   = 1'b1;
            st.grant_target = waiters[0];
            holder_on       = 1'b1;
            holder_id       = waiters[0];
            waiters[0]      = waiters[waiter_cnt - 1];
            waiter_cnt--;
        end
    endtask

    task automatic apply_event(input mode_t md, input logic [7:0] id,
                               output lock_status_t st);
        logic listed;
        st = '0;
        case (md)
            MODE_REQ: begin
                if (!holder_on) begin
                    holder_on          = 1'b1;
                    holder_id          = id;
                    st.request_granted = 1'b1;
                    st.grant_made      = 1'b1;
                    st.grant_target    = id;
                end else begin
                    listed = 1'b0;
                    for (int i = 0; i < waiter_cnt; i++) begin
                        if (waiters[i] == id) listed = 1'b1;
                    end
                    if (!listed) begin
                        if (waiter_cnt < LIST_DEPTH) begin
                            waiters[waiter_cnt] = id;
                            waiter_cnt++;
                        end else begin
                            st.list_overflow = 1'b1;
                        end
                    end
                end
            end
            MODE_REL: begin
                if (holder_on && holder_id == id) begin
                    holder_on = 1'b0;
                    holder_id = '0;
                    promote_head(st);
                end else begin
                    take_off_list(id);
                end
            end
            MODE_REM: begin
                if (holder_on && holder_id == id) begin
                    holder_on = 1'b0;
                    holder_id = '0;
                end
                take_off_list(id);
                promote_head(st);
            end
            default: begin
            end
        endcase
        st.holder_present = holder_on;
        st.holder_now     = holder_on ? holder_id : 8'd0;
        st.waiting_total  = 5'(waiter_cnt);
    endtask

    always @(posedge aclk) begin : watch
        lock_status_t exp_st;
        lock_status_t got_st;
        lock_status_t new_st;
        if (!aresetn) begin
            holder_on  = 1'b0;
            holder_id  = '0;
            waiter_cnt = 0;
            due_status_q.delete();
        end else begin
            // result side first: a result can never belong to a same-edge input
            if (m_valid && m_ready) begin
                got_st.request_granted = m_request_granted;
                got_st.grant_made      = m_grant_made;
                got_st.grant_target    = m_grant_target;
                got_st.holder_present  = m_holder_present;
                got_st.holder_now      = m_holder_now;
                got_st.waiting_total   = m_waiting_total;
                got_st.list_overflow   = m_list_overflow;
                if (due_status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing outstanding", $time);
                end else begin
                    exp_st = due_status_q.pop_front();
                    if (got_st !== exp_st) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch gr/gm/tgt/hp/hold/wait/ovf", $time);
                            $display("  got %b %b %02h %b %02h %0d %b",
                                got_st.request_granted, got_st.grant_made,
                                got_st.grant_target, got_st.holder_present,
                                got_st.holder_now, got_st.waiting_total,
                                got_st.list_overflow);
                            $display("  exp %b %b %02h %b %02h %0d %b",
                                exp_st.request_granted, exp_st.grant_made,
                                exp_st.grant_target, exp_st.holder_present,
                                exp_st.holder_now, exp_st.waiting_total,
                                exp_st.list_overflow);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_event(mode_t'(s_mode), s_agent_id, new_st);
                due_status_q.push_back(new_st);
                n_events++;
                if (new_st.request_granted) n_direct++;
                else if (new_st.grant_made) n_promote++;
                if (new_st.list_overflow) n_drop++;
            end
        end
        fail_count    <= mismatches;
        pending       <= due_status_q.size();
        events_seen   <= n_events;
        direct_grants <= n_direct;
        promotions    <= n_promote;
        list_drops    <= n_drop;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import shlock_pkg::*;

    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_CRAWL} rx_style_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic [1:0] s_mode     = '0;
    logic [7:0] s_agent_id = '0;
    logic       m_ready    = 1'b0;

    wire        s_ready;
    wire        m_valid;
    wire        m_request_granted;
    wire        m_grant_made;
    wire  [7:0] m_grant_target;
    wire        m_holder_present;
    wire  [7:0] m_holder_now;
    wire  [4:0] m_waiting_total;
    wire        m_list_overflow;

    int fail_count;
    int pending;
    int events_seen;
    int direct_grants;
    int promotions;
    int list_drops;

    rx_style_t rx_style  = RX_OPEN;
    int        rx_left   = 0;
    int        burst_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    single_holder_lock_with_wait_list u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_agent_id        (s_agent_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_request_granted (m_request_granted),
        .m_grant_made      (m_grant_made),
        .m_grant_target    (m_grant_target),
        .m_holder_present  (m_holder_present),
        .m_holder_now      (m_holder_now),
        .m_waiting_total   (m_waiting_total),
        .m_list_overflow   (m_list_overflow)
    );

    lock_status_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_agent_id        (s_agent_id),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_request_granted (m_request_granted),
        .m_grant_made      (m_grant_made),
        .m_grant_target    (m_grant_target),
        .m_holder_present  (m_holder_present),
        .m_holder_now      (m_holder_now),
        .m_waiting_total   (m_waiting_total),
        .m_list_overflow   (m_list_overflow),
        .fail_count        (fail_count),
        .pending           (pending),
        .events_seen       (events_seen),
        .direct_grants     (direct_grants),
        .promotions        (promotions),
        .list_drops        (list_drops)
    );

    // result-side backpressure; the style is redrawn at random when its countdown runs out
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
            rx_left  <= $urandom_range(20, 200);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_style)
            RX_OPEN:  m_ready <= 1'b1;
            RX_COIN:  m_ready <= 1'($urandom_range(0, 1));
            RX_SLOW:  m_ready <= ($urandom_range(0, 3) == 0);
            default:  m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // one transaction; valid stays up for a following one
    task automatic send_event(input mode_t md, input logic [7:0] id);
        s_valid    <= 1'b1;
        s_mode     <= md;
        s_agent_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int    pool_sz;
        int    base;
        int    req_pct;
        int    rel_pct;
        int    pick;
        int    gap;
        mode_t md;
        logic [7:0] id;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, back to back
        send_event(MODE_NONE, 8'hAA);
        send_event(MODE_REQ, 8'h00);
        send_event(MODE_REQ, 8'h00);              // holder asks again, gets listed
        send_event(MODE_REQ, 8'h00);              // already listed
        for (int i = 1; i < LIST_DEPTH; i++)
            send_event(MODE_REQ, 8'(i));
        send_event(MODE_REQ, 8'hFF);              // list full
        send_event(MODE_REL, 8'h05);              // non-holder leaves the list
        send_event(MODE_REM, 8'h80);              // unknown id while held
        send_event(MODE_REL, 8'h00);              // holder release, promotion
        send_event(MODE_REM, 8'h00);              // holder removed, promotion
        send_event(MODE_NONE, 8'h55);
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin pool_sz = 4;   req_pct = 40; rel_pct = 35; end
                1: begin pool_sz = 24;  req_pct = 75; rel_pct = 10; end
                2: begin pool_sz = 256; req_pct = 50; rel_pct = 25; end
                default: begin pool_sz = 10; req_pct = 45; rel_pct = 30; end
            endcase
            base = $urandom_range(0, 256 - pool_sz);
            for (int k = 0; k < 50; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < req_pct) md = MODE_REQ;
                else if (pick < req_pct + rel_pct) md = MODE_REL;
                else if (pick < 97) md = MODE_REM;
                else md = MODE_NONE;
                id = 8'(base + $urandom_range(0, pool_sz - 1));
                send_event(md, id);
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                    if (gap != 0) begin
                        s_valid <= 1'b0;
                        repeat (gap) @(posedge aclk);
                    end
                end else begin
                    burst_left--;
                end
            end
            if (ph % 2 == 1) drain_results();
        end

        drain_results();
        repeat (40) @(posedge aclk);

        $display("covered %0d events: %0d immediate grants, %0d promotions",
            events_seen, direct_grants, promotions);
        $display("%0d requests dropped on a full wait list, %0d mismatches",
            list_drops, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("single_holder_lock_with_wait_list test passed");
        end else begin
            $display("single_holder_lock_with_wait_list test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("single_holder_lock_with_wait_list test failed");
        $finish;
    end

endmodule
